>>> hw/rtl/ufv_pkg.sv
// Shared types and constants for the UTF-8 file name validator.
// No dependencies; used by ufv_step and utf8_filename_validator_top.
package ufv_pkg;

    localparam logic [7:0] MAX_NAME_BYTES_RESET = 8'd240;
    localparam logic [7:0] BYTE_COUNT_SAT       = 8'hff;
    localparam logic [7:0] DOT_BYTE             = 8'h2e;

    // Lead byte ranges of multi-byte sequences.
    localparam logic [7:0] LEAD2_LO = 8'hc2;
    localparam logic [7:0] LEAD2_HI = 8'hdf;
    localparam logic [7:0] LEAD3_LO = 8'he0;
    localparam logic [7:0] LEAD3_HI = 8'hef;
    localparam logic [7:0] LEAD4_LO = 8'hf0;
    localparam logic [7:0] LEAD4_HI = 8'hf4;

    // Sequence length classes.
    localparam logic [1:0] CLS_ONE   = 2'd0;
    localparam logic [1:0] CLS_TWO   = 2'd1;
    localparam logic [1:0] CLS_THREE = 2'd2;
    localparam logic [1:0] CLS_FOUR  = 2'd3;

    typedef struct packed {
        logic [7:0]  byte_count;
        logic [1:0]  pending_continuations;
        logic [20:0] partial_code_point;
        logic [1:0]  sequence_length_class;
        logic        rejected_flag;
        logic        all_dots_flag;
    } ufv_state_t;

    localparam ufv_state_t STATE_CLEAR = '{
        byte_count:            8'd0,
        pending_continuations: 2'd0,
        partial_code_point:    21'd0,
        sequence_length_class: CLS_ONE,
        rejected_flag:         1'b0,
        all_dots_flag:         1'b1
    };

endpackage

>>> hw/rtl/ufv_step.sv
// Per-byte next-state and verdict logic of the file name validator.
// Depends on ufv_pkg for the state struct and constants.
module ufv_step (
    input  ufv_pkg::ufv_state_t cur_state,
    input  logic [7:0]          byte_value,
    input  logic                byte_present,
    input  logic [7:0]          max_name_bytes,
    output ufv_pkg::ufv_state_t nxt_state,
    output logic                accepted
);

    localparam logic [20:0] CP_MAX     = 21'h10ffff;
    localparam logic [20:0] SURR_LO    = 21'h00d800;
    localparam logic [20:0] SURR_HI    = 21'h00dfff;
    localparam logic [20:0] CTRL_LIMIT = 21'd32;
    localparam logic [20:0] DEL_LO     = 21'd127;
    localparam logic [20:0] C1_HI      = 21'd159;
    localparam logic [20:0] SLASH      = 21'h00002f;
    localparam logic [20:0] BACKSLASH  = 21'h00005c;
    localparam logic [20:0] ALM        = 21'h00061c;
    localparam logic [20:0] LRM        = 21'h00200e;
    localparam logic [20:0] RLM        = 21'h00200f;
    localparam logic [20:0] LSEP_LO    = 21'h002028;
    localparam logic [20:0] LSEP_HI    = 21'h00202e;
    localparam logic [20:0] ISO_LO     = 21'h002066;
    localparam logic [20:0] ISO_HI     = 21'h002069;

    function automatic logic cp_bad(input logic [20:0] cp, input logic [1:0] cls);
        logic [20:0] min_cp;
        case (cls)
            ufv_pkg::CLS_ONE:   min_cp = 21'h000000;
            ufv_pkg::CLS_TWO:   min_cp = 21'h000080;
            ufv_pkg::CLS_THREE: min_cp = 21'h000800;
            ufv_pkg::CLS_FOUR:  min_cp = 21'h010000;
            default:            min_cp = 21'h000000;
        endcase
        cp_bad = (cp < min_cp) || (cp > CP_MAX)
              || (cp >= SURR_LO && cp <= SURR_HI)
              || (cp < CTRL_LIMIT) || (cp >= DEL_LO && cp <= C1_HI)
              || (cp == SLASH) || (cp == BACKSLASH)
              || (cp == ALM) || (cp == LRM) || (cp == RLM)
              || (cp >= LSEP_LO && cp <= LSEP_HI)
              || (cp >= ISO_LO && cp <= ISO_HI);
    endfunction

    ufv_pkg::ufv_state_t tk;
    logic [20:0]         cp_shift;
    logic [1:0]          pend_dec;

    assign cp_shift = {cur_state.partial_code_point[14:0], byte_value[5:0]};
    assign pend_dec = cur_state.pending_continuations - 2'd1;

    always_comb begin
        tk = cur_state;
        if (cur_state.byte_count != ufv_pkg::BYTE_COUNT_SAT) begin
            tk.byte_count = cur_state.byte_count + 8'd1;
        end
        if (byte_value != ufv_pkg::DOT_BYTE) begin
            tk.all_dots_flag = 1'b0;
        end
        if (cur_state.pending_continuations == 2'd0) begin
            if (!byte_value[7]) begin
                tk.sequence_length_class = ufv_pkg::CLS_ONE;
                if (cp_bad({13'd0, byte_value}, ufv_pkg::CLS_ONE)) begin
                    tk.rejected_flag = 1'b1;
                end
            end else if (byte_value >= ufv_pkg::LEAD2_LO && byte_value <= ufv_pkg::LEAD2_HI) begin
                tk.pending_continuations = 2'd1;
                tk.partial_code_point    = {16'd0, byte_value[4:0]};
                tk.sequence_length_class = ufv_pkg::CLS_TWO;
            end else if (byte_value >= ufv_pkg::LEAD3_LO && byte_value <= ufv_pkg::LEAD3_HI) begin
                tk.pending_continuations = 2'd2;
                tk.partial_code_point    = {17'd0, byte_value[3:0]};
                tk.sequence_length_class = ufv_pkg::CLS_THREE;
            end else if (byte_value >= ufv_pkg::LEAD4_LO && byte_value <= ufv_pkg::LEAD4_HI) begin
                tk.pending_continuations = 2'd3;
                tk.partial_code_point    = {18'd0, byte_value[2:0]};
                tk.sequence_length_class = ufv_pkg::CLS_FOUR;
            end else begin
                tk.rejected_flag = 1'b1;
            end
        end else if (byte_value[7:6] != 2'b10) begin
            // A stray non-continuation byte abandons the open sequence.
            tk.rejected_flag         = 1'b1;
            tk.pending_continuations = 2'd0;
            tk.partial_code_point    = 21'd0;
        end else begin
            tk.pending_continuations = pend_dec;
            if (pend_dec == 2'd0) begin
                if (cp_bad(cp_shift, cur_state.sequence_length_class)) begin
                    tk.rejected_flag = 1'b1;
                end
                tk.partial_code_point = 21'd0;
            end else begin
                tk.partial_code_point = cp_shift;
            end
        end
    end

    assign nxt_state = byte_present ? tk : cur_state;

    assign accepted = !nxt_state.rejected_flag
                   && (nxt_state.pending_continuations == 2'd0)
                   && (nxt_state.byte_count != 8'd0)
                   && (nxt_state.byte_count != ufv_pkg::BYTE_COUNT_SAT)
                   && (nxt_state.byte_count <= max_name_bytes)
                   && !(nxt_state.all_dots_flag
                        && (nxt_state.byte_count == 8'd1 || nxt_state.byte_count == 8'd2));

endmodule

>>> hw/rtl/utf8_filename_validator_top.sv
// Top level of the streaming UTF-8 file name validator.
// Depends on ufv_pkg and ufv_step.
//
// A file name arrives one byte per item on the slave stream; the item with
// tlast high ends the name and yields exactly one verdict item on the master
// stream (m_tdata bit 0 high means the name is a safe basename). Items
// without tlast yield nothing. The block sustains one item per clock while no
// last item is held back by a stalled master stream: an accepted item is
// held in an input register, from which the combinational per-byte decoder
// updates the name state and, for a last item, loads the verdict into the
// output register. A stalled master stream holds back the slave stream only
// while a last item waits in the input register for the output register,
// and then every item behind it waits as well. The byte limit register may
// be written only while no name is in flight; it resets to 240. After each
// verdict the name state clears.
module utf8_filename_validator_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic       s_tuser,   // [0] byte_present
    input  logic       s_tlast,   // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] accepted, [7:1] zero
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata  // max_name_bytes
);

    // Input register stage.
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_present_reg;
    logic       in_last_reg;

    // Name state and byte limit.
    ufv_pkg::ufv_state_t state_reg;
    ufv_pkg::ufv_state_t state_next;
    logic [7:0]          max_bytes_reg;

    // Output register stage.
    logic out_vld_reg;
    logic out_acc_reg;

    logic step_acc;
    logic out_free;
    logic advance;

    // The output register can take a verdict when empty or being emptied.
    assign out_free = !out_vld_reg || m_tready;
    // An item without tlast never needs the output register.
    assign advance  = in_vld_reg && (!in_last_reg || out_free);
    assign s_tready = !in_vld_reg || advance;

    ufv_step u_step (
        .cur_state      (state_reg),
        .byte_value     (in_byte_reg),
        .byte_present   (in_present_reg),
        .max_name_bytes (max_bytes_reg),
        .nxt_state      (state_next),
        .accepted       (step_acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            state_reg     <= ufv_pkg::STATE_CLEAR;
            max_bytes_reg <= ufv_pkg::MAX_NAME_BYTES_RESET;
        end else begin
            if (cfg_we) begin
                max_bytes_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg <= in_last_reg ? ufv_pkg::STATE_CLEAR : state_next;
            end
            if (advance && in_last_reg) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_acc_reg <= step_acc;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_acc_reg};

    // A verdict always leaves the name state fully cleared.
    a_clear_after_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (state_reg == ufv_pkg::STATE_CLEAR))
        else $error("name state not cleared after verdict");

    // A verdict only appears after a last item went through the decoder.
    a_verdict_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(advance && in_last_reg))
        else $error("verdict without a last item");

    // Pending continuations never exceed what the lead byte announced.
    a_pending_within_class: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pending_continuations <= state_reg.sequence_length_class)
        else $error("pending continuations exceed sequence class");

    // A last item waiting behind a full, stalled output register is not lost.
    a_last_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && in_last_reg && !out_free) |=> (in_vld_reg && in_last_reg))
        else $error("stalled last item dropped");

endmodule

>>> tb/utf8_filename_validator_top_test.sv
// Self-checking testbench for the streaming UTF-8 file name validator.
// Depends on ufv_pkg and utf8_filename_validator_top; predicts every verdict
// from its own copy of the name state and checks it against the master stream.
module utf8_filename_validator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ufv_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_MAX    = 10;
    // Idle cycles after the last expected verdict let trailing items that
    // produce no verdict drain as well.
    localparam int SETTLE_CYCLES = 6;

    // Code points and ranges that a safe basename may not contain.
    localparam logic [20:0] CP_SPACE     = 21'h20;
    localparam logic [20:0] CP_DEL       = 21'h7f;
    localparam logic [20:0] CP_C1_LAST   = 21'd159;
    localparam logic [20:0] CP_SLASH     = 21'h2f;
    localparam logic [20:0] CP_BACKSLASH = 21'h5c;
    localparam logic [20:0] CP_ALM       = 21'h061c;
    localparam logic [20:0] CP_LRM       = 21'h200e;
    localparam logic [20:0] CP_RLM       = 21'h200f;
    localparam logic [20:0] CP_LS        = 21'h2028;
    localparam logic [20:0] CP_RLO       = 21'h202e;
    localparam logic [20:0] CP_LRI       = 21'h2066;
    localparam logic [20:0] CP_PDI       = 21'h2069;
    localparam logic [20:0] CP_SURR_LO   = 21'hd800;
    localparam logic [20:0] CP_SURR_HI   = 21'hdfff;
    localparam logic [20:0] CP_MAX       = 21'h10ffff;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tuser   = 1'b0;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;

    utf8_filename_validator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Both sides idle at random while gaps_on is set.
    logic gaps_on = 1'b1;

    // Shadow of the block: byte limit and the state of the name in progress.
    logic [7:0]  limit_q;
    logic [7:0]  seen_bytes;
    logic [1:0]  conts_left;
    logic [1:0]  seq_cls;
    logic [20:0] cp_acc;
    logic        name_bad;
    logic        only_dots;

    logic        expected_verdicts[$];
    logic [7:0]  name_buf[$];
    logic        wanted_verdict;

    int items_sent    = 0;
    int bytes_sent    = 0;
    int verdicts_seen = 0;
    int accepts_seen  = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    task automatic clear_name_state();
        seen_bytes = '0;
        conts_left = '0;
        cp_acc     = '0;
        seq_cls    = CLS_ONE;
        name_bad   = 1'b0;
        only_dots  = 1'b1;
    endtask

    function automatic logic cp_forbidden(input logic [20:0] cp, input logic [1:0] cls);
        logic [20:0] floor_cp;
        case (cls)
            CLS_TWO:   floor_cp = 21'h80;
            CLS_THREE: floor_cp = 21'h800;
            CLS_FOUR:  floor_cp = 21'h10000;
            default:   floor_cp = '0;
        endcase
        return cp < floor_cp || cp > CP_MAX
            || (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
            || cp < CP_SPACE || (cp >= CP_DEL && cp <= CP_C1_LAST)
            || cp == CP_SLASH || cp == CP_BACKSLASH
            || cp == CP_ALM || cp == CP_LRM || cp == CP_RLM
            || (cp >= CP_LS && cp <= CP_RLO)
            || (cp >= CP_LRI && cp <= CP_PDI);
    endfunction

    // Advances the shadow name state by one real byte.
    task automatic decode_byte(input logic [7:0] b);
        if (seen_bytes != BYTE_COUNT_SAT) seen_bytes++;
        if (b != DOT_BYTE) only_dots = 1'b0;
        if (conts_left == 2'd0) begin
            if (!b[7]) begin
                seq_cls = CLS_ONE;
                if (cp_forbidden({13'd0, b}, CLS_ONE)) name_bad = 1'b1;
            end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                conts_left = 2'd1;
                cp_acc     = {16'd0, b[4:0]};
                seq_cls    = CLS_TWO;
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                conts_left = 2'd2;
                cp_acc     = {17'd0, b[3:0]};
                seq_cls    = CLS_THREE;
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                conts_left = 2'd3;
                cp_acc     = {18'd0, b[2:0]};
                seq_cls    = CLS_FOUR;
            end else begin
                name_bad = 1'b1;
            end
        end else if (b[7:6] != 2'b10) begin
            // A byte that is not a continuation abandons the sequence.
            name_bad   = 1'b1;
            conts_left = 2'd0;
            cp_acc     = '0;
        end else begin
            cp_acc     = {cp_acc[14:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left == 2'd0) begin
                if (cp_forbidden(cp_acc, seq_cls)) name_bad = 1'b1;
                cp_acc = '0;
            end
        end
    endtask

    function automatic logic name_ok();
        return !name_bad && conts_left == 2'd0
            && seen_bytes != 8'd0 && seen_bytes != BYTE_COUNT_SAT
            && seen_bytes <= limit_q
            && !(only_dots && (seen_bytes == 8'd1 || seen_bytes == 8'd2));
    endfunction

    // Offers one item, waits for the handshake and updates the shadow state.
    task automatic send_item(input logic [7:0] b, input logic present, input logic is_last);
        while (gaps_on && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (present || is_last) items_sent++;
        if (present) begin
            bytes_sent++;
            decode_byte(b);
        end
        if (is_last) begin
            expected_verdicts.push_back(name_ok());
            clear_name_state();
        end
    endtask

    // Sends name_buf as one name, now and then with an ignored item in between.
    // With sep_last the end of the name travels in an item without a byte.
    task automatic send_name(input logic sep_last);
        int k;
        for (k = 0; k < name_buf.size(); k++) begin
            if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(name_buf[k], 1'b1, !sep_last && k == name_buf.size() - 1);
        end
        if (sep_last || name_buf.size() == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic send_letters(input int n);
        name_buf.delete();
        repeat (n) name_buf.push_back(8'($urandom_range(8'h61, 8'h7a)));
        send_name(1'b0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The limit only changes between names, once the block has gone quiet.
    task automatic write_limit(input logic [7:0] value);
        wait_drained();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        limit_q    = value;
        @(posedge aclk);
    endtask

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);                                  // empty name
        send_item(DOT_BYTE, 1'b1, 1'b1);                               // "."
        send_item(DOT_BYTE, 1'b1, 1'b0);
        send_item(DOT_BYTE, 1'b1, 1'b1);                               // ".."
        send_item(8'h00, 1'b1, 1'b1);                                  // NUL
        send_item(8'hff, 1'b1, 1'b1);                                  // never a legal byte
        send_item(8'hc3, 1'b1, 1'b0); send_item(8'h41, 1'b1, 1'b1);    // broken sequence
        send_item(8'he2, 1'b1, 1'b0); send_item(8'h82, 1'b1, 1'b1);    // truncated at the end
        send_item(8'he0, 1'b1, 1'b0); send_item(8'h80, 1'b1, 1'b0);    // overlong slash
        send_item(8'haf, 1'b1, 1'b1);
        send_item(8'hed, 1'b1, 1'b0); send_item(8'ha0, 1'b1, 1'b0);    // surrogate
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'hf4, 1'b1, 1'b0); send_item(8'h90, 1'b1, 1'b0);    // above U+10FFFF
        send_item(8'h80, 1'b1, 1'b0); send_item(8'h80, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);                                  // ignored item
        send_item(CP_SLASH[7:0], 1'b1, 1'b1);                          // "/"
        send_item(8'hf0, 1'b1, 1'b0); send_item(8'h9f, 1'b1, 1'b0);    // valid four-byte
        send_item(8'h98, 1'b1, 1'b0); send_item(8'h80, 1'b1, 1'b1);
    endtask

    task automatic test_limit_edges();
        // The reset limit first, then the extremes of the register.
        send_letters(240);
        send_letters(241);
        write_limit(8'd1);
        send_letters(1);
        send_letters(2);
        write_limit(8'd0);
        send_letters(1);
        write_limit(8'd3);
        send_letters(3);
        send_letters(4);
        write_limit(8'd254);
        send_letters(254);
        send_letters(255);
        // The counter saturates at 255, which rejects even under the top limit.
        write_limit(8'd255);
        send_letters(255);
        send_letters(256);
    endtask

    // Mostly well-formed names with random content; the rest dots, noise,
    // names around the limit and empty names.
    task automatic send_random_names(input int item_goal);
        int          start_items, kind, n, nb, pos;
        logic [20:0] cp;
        start_items = items_sent;
        while (items_sent - start_items < item_goal) begin
            name_buf.delete();
            kind = $urandom_range(99);
            if (kind < 62 || (kind < 95 && kind >= 88 && limit_q > 40)) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    case ($urandom_range(5))
                        0: cp = 21'($urandom_range(8'h20, 8'h7e));
                        1: begin
                            case ($urandom_range(3))
                                0: cp = CP_DEL;
                                1: cp = CP_SLASH;
                                2: cp = CP_BACKSLASH;
                                default: cp = 21'($urandom_range(8'h1f));
                            endcase
                        end
                        2: cp = 21'($urandom_range(12'h080, 12'h7ff));
                        3: cp = 21'($urandom_range(16'h0800, 16'hffff));
                        4: begin
                            case ($urandom_range(26))
                                0: cp = 21'h061b;   1: cp = CP_ALM;      2: cp = 21'h061d;
                                3: cp = 21'h200d;   4: cp = CP_LRM;      5: cp = CP_RLM;
                                6: cp = 21'h2010;   7: cp = 21'h2027;    8: cp = CP_LS;
                                9: cp = 21'h202b;   10: cp = CP_RLO;     11: cp = 21'h202f;
                                12: cp = 21'h2065;  13: cp = CP_LRI;     14: cp = CP_PDI;
                                15: cp = 21'h206a;  16: cp = 21'hd7ff;   17: cp = CP_SURR_LO;
                                18: cp = CP_SURR_HI; 19: cp = 21'he000;  20: cp = 21'hffff;
                                21: cp = 21'h10000; 22: cp = CP_MAX;     23: cp = 21'h110000;
                                24: cp = 21'h1fffff; 25: cp = CP_C1_LAST;
                                default: cp = 21'ha0;
                            endcase
                        end
                        default: cp = 21'($urandom_range(21'h10000, CP_MAX));
                    endcase
                    nb = cp < 21'h80 ? 1 : cp < 21'h800 ? 2 : cp < 21'h10000 ? 3 : 4;
                    // Now and then an overlong form of the same code point.
                    if (nb < 4 && $urandom_range(9) == 0) nb++;
                    case (nb)
                        1: name_buf.push_back({1'b0, cp[6:0]});
                        2: begin
                            name_buf.push_back({3'b110, cp[10:6]});
                            name_buf.push_back({2'b10, cp[5:0]});
                        end
                        3: begin
                            name_buf.push_back({4'b1110, cp[15:12]});
                            name_buf.push_back({2'b10, cp[11:6]});
                            name_buf.push_back({2'b10, cp[5:0]});
                        end
                        default: begin
                            name_buf.push_back({5'b11110, cp[20:18]});
                            name_buf.push_back({2'b10, cp[17:12]});
                            name_buf.push_back({2'b10, cp[11:6]});
                            name_buf.push_back({2'b10, cp[5:0]});
                        end
                    endcase
                end
                // Break a few sequences: a stray byte, a lost byte or a dangling lead.
                if ($urandom_range(9) == 0) begin
                    pos = $urandom_range(name_buf.size() - 1);
                    case ($urandom_range(2))
                        0: name_buf[pos] = 8'($urandom_range(255));
                        1: name_buf.delete(pos);
                        default: name_buf.push_back(8'($urandom_range(LEAD2_LO, LEAD4_HI)));
                    endcase
                end
            end else if (kind < 72) begin
                n = $urandom_range(1, 3);
                repeat (n) name_buf.push_back(DOT_BYTE);
                if ($urandom_range(3) == 0)
                    name_buf.insert($urandom_range(n), 8'($urandom_range(8'h20, 8'h7e)));
            end else if (kind < 88) begin
                n = $urandom_range(1, 8);
                repeat (n) name_buf.push_back(8'($urandom_range(255)));
            end else if (kind < 95) begin
                n = int'(limit_q) + $urandom_range(2) - 1;
                repeat (n) name_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
            end
            send_name($urandom_range(99) < 15);
        end
    endtask

    task automatic test_random_names();
        write_limit(8'($urandom_range(1, 254)));
        send_random_names(50);
        write_limit(8'd1);
        send_random_names(40);
        write_limit(8'd254);
        send_random_names(50);
        write_limit(8'($urandom_range(2, 40)));
        send_random_names(40);
    endtask

    task automatic test_back_to_back();
        wait_drained();
        gaps_on = 1'b0;
        write_limit(8'($urandom_range(1, 254)));
        send_random_names(100);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // The verdict sink stalls at random while gaps are allowed.
    always @(posedge aclk) begin
        m_tready <= !gaps_on || $urandom_range(99) >= 25;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            verdicts_seen++;
            if (m_tdata[0] === 1'b1) accepts_seen++;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("verdict %0d arrived with none expected, m_tdata=%h",
                             verdicts_seen, m_tdata);
            end else begin
                wanted_verdict = expected_verdicts.pop_front();
                if (m_tdata[0] !== wanted_verdict || m_tdata[7:1] !== 7'd0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("verdict %0d: expected accepted=%0b pad=00, got accepted=%0b pad=%h",
                                 verdicts_seen, wanted_verdict, m_tdata[0], m_tdata[7:1]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d verdicts outstanding",
                     cycle_count, expected_verdicts.size());
            $display("utf8_filename_validator_top: mismatch");
            $finish;
        end
    end

    initial begin
        limit_q = MAX_NAME_BYTES_RESET;
        clear_name_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_limit_edges();
        test_random_names();
        test_back_to_back();
        wait_drained();
        $display("checked %0d verdicts (%0d accepted) from %0d items and %0d name bytes",
                 verdicts_seen, accepts_seen, items_sent, bytes_sent);
        $display("byte limits 0, 1, 3, 240, 254, 255 and random; %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("utf8_filename_validator_top: match");
        end else begin
            $display("utf8_filename_validator_top: mismatch");
        end
        $finish;
    end

endmodule
